### src/chkv_pkg.sv
package chkv_pkg;

    // Default table sizes
    localparam int BUCKETS_DEF = 256;
    localparam int ENTRIES_DEF = 1024;

    // Field widths
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int BCNT_W  = 9;
    localparam int STAT_W  = 3;
    localparam int BIDX_W  = 16;   // wide enough for any bucket index
    localparam int DIV_BITS = 4;   // key bits consumed per remainder step

    // Request modes
    localparam logic MODE_SET = 1'b0;
    localparam logic MODE_GET = 1'b1;

    // Result codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    // Classified request handed from front to back
    typedef struct packed {
        logic              mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [BIDX_W-1:0] bucket;
    } req_t;

endpackage

### src/chkv_front.sv
module chkv_front
    import chkv_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BCNT_W-1:0] bucket_count,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_mode,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [VAL_W-1:0]  in_value,
    output logic              q_valid,
    input  logic              q_ready,
    output req_t              q_data
);

    localparam int STEPS = KEY_W / DIV_BITS;
    localparam int SC_W  = $clog2(STEPS + 1);

    typedef enum logic [2:0]
    {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [SC_W-1:0]   cnt_reg, cnt_next;
    logic [BCNT_W-1:0] rem_reg, rem_next;
    logic [BCNT_W-1:0] div_reg;
    logic [KEY_W-1:0]  shf_reg;
    logic              mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [BCNT_W-1:0] eff;

    // Effective bucket count: zero reads as one, saturate at table size
    always_comb
    begin
        if (bucket_count == '0)
            eff = BCNT_W'(1);
        else if (17'(bucket_count) > 17'(BUCKETS))
            eff = BCNT_W'(BUCKETS);
        else
            eff = bucket_count;
    end

    // Restoring remainder, a few key bits per cycle
    always_comb
    begin
        logic [BCNT_W:0] t;
        t = '0;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            t = {rem_next, shf_reg[KEY_W-1-i]};
            if (t >= {1'b0, div_reg})
                t = t - {1'b0, div_reg};
            rem_next = t[BCNT_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_DIV;
                    cnt_next   = '0;
                end
            end
            F_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SC_W'(STEPS - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (q_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Request payload and divider datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_valid)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
            val_reg  <= in_value;
            shf_reg  <= in_key;
            div_reg  <= eff;
            rem_reg  <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rem_reg <= rem_next;
            shf_reg <= shf_reg << DIV_BITS;
        end
    end

    assign in_ready      = (state_reg == F_IDLE);
    assign q_valid       = (state_reg == F_PUSH);
    assign q_data.mode   = mode_reg;
    assign q_data.key    = key_reg;
    assign q_data.value  = val_reg;
    assign q_data.bucket = BIDX_W'(rem_reg);

endmodule

### src/chkv_queue.sv
module chkv_queue
    import chkv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  req_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output req_t rd_data
);

    // Two-slot FIFO
    req_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wr_data;
    end

endmodule

### src/chkv_back.sv
module chkv_back
    import chkv_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] out_status,
    output logic [VAL_W-1:0]  out_value
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW = $clog2(ENTRIES + 1);

    typedef enum logic [6:0]
    {
        B_IDLE = 7'b0000001,
        B_HRD  = 7'b0000010,
        B_HCHK = 7'b0000100,
        B_ERD  = 7'b0001000,
        B_ECMP = 7'b0010000,
        B_DO   = 7'b0100000,
        B_LINK = 7'b1000000
    } bstate_t;

    // Storage
    logic [IW-1:0]    head_mem [BUCKETS];
    logic [BUCKETS-1:0] head_vld_reg;
    logic [KEY_W-1:0] key_mem  [ENTRIES];
    logic [VAL_W-1:0] val_mem  [ENTRIES];
    logic [IW:0]      next_mem [ENTRIES];   // {valid, index}

    bstate_t          state_reg, state_next;
    logic             mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [BW-1:0]    bkt_reg;
    logic [IW-1:0]    cur_reg, cur_next;
    logic [IW-1:0]    prev_reg, prev_next;
    logic             pvld_reg, pvld_next;
    logic             have_reg, have_next;
    logic [UW-1:0]    steps_reg, steps_next;
    logic [UW-1:0]    used_reg;
    logic [IW-1:0]    head_rd;
    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;
    logic [IW:0]      next_rd;
    logic             done, ins_fire, full;
    logic [IW-1:0]    new_idx;

    assign full    = (used_reg == UW'(ENTRIES));
    assign new_idx = IW'(used_reg);
    assign done    = (state_reg == B_DO) && (!out_valid || out_ready);
    assign ins_fire = done && (mode_reg == MODE_SET) && !have_reg && !full;
    assign q_ready = (state_reg == B_IDLE);

    // Chain walk sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        pvld_next  = pvld_reg;
        have_next  = have_reg;
        steps_next = steps_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_HRD;
                    pvld_next  = 1'b0;
                    steps_next = '0;
                end
            end
            B_HRD: state_next = B_HCHK;
            B_HCHK:
            begin
                have_next = head_vld_reg[bkt_reg];
                cur_next  = head_rd;
                state_next = head_vld_reg[bkt_reg] ? B_ERD : B_DO;
            end
            B_ERD: state_next = B_ECMP;
            B_ECMP:
            begin
                if (key_rd == key_reg)
                    state_next = B_DO;
                else
                begin
                    prev_next  = cur_reg;
                    pvld_next  = 1'b1;
                    cur_next   = next_rd[IW-1:0];
                    steps_next = steps_reg + 1'b1;
                    if (!next_rd[IW] || (steps_reg + 1'b1) == UW'(ENTRIES))
                    begin
                        have_next  = 1'b0;
                        state_next = B_DO;
                    end
                    else
                        state_next = B_ERD;
                end
            end
            B_DO:
            begin
                if (done)
                    state_next = (ins_fire && pvld_reg) ? B_LINK : B_IDLE;
            end
            B_LINK: state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            used_reg     <= '0;
            head_vld_reg <= '0;
            out_valid    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ins_fire)
            begin
                used_reg <= used_reg + 1'b1;
                if (!pvld_reg)
                    head_vld_reg[bkt_reg] <= 1'b1;
            end
            if (done)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && q_valid)
        begin
            mode_reg <= q_data.mode;
            key_reg  <= q_data.key;
            val_reg  <= q_data.value;
            bkt_reg  <= BW'(q_data.bucket);
        end
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        pvld_reg  <= pvld_next;
        have_reg  <= have_next;
        steps_reg <= steps_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_value <= '0;
            if (mode_reg == MODE_GET)
            begin
                out_status <= have_reg ? ST_FOUND : ST_NOT_FOUND;
                if (have_reg)
                    out_value <= val_rd;
            end
            else if (have_reg)
            begin
                out_status <= ST_UPDATED;
                out_value  <= val_rd;
            end
            else
                out_status <= full ? ST_FULL : ST_INSERTED;
        end
    end

    // Bucket head memory
    always_ff @(posedge clk)
    begin
        if (ins_fire && !pvld_reg)
            head_mem[bkt_reg] <= new_idx;
        head_rd <= head_mem[bkt_reg];
    end

    // Pool key memory
    always_ff @(posedge clk)
    begin
        if (ins_fire)
            key_mem[new_idx] <= key_reg;
        key_rd <= key_mem[cur_reg];
    end

    // Pool value memory
    always_ff @(posedge clk)
    begin
        if (ins_fire)
            val_mem[new_idx] <= val_reg;
        else if (done && mode_reg == MODE_SET && have_reg)
            val_mem[cur_reg] <= val_reg;
        val_rd <= val_mem[cur_reg];
    end

    // Pool link memory: new tail on insert, predecessor link in the cycle after (B_LINK)
    always_ff @(posedge clk)
    begin
        if (ins_fire)
            next_mem[new_idx] <= '0;
        else if (state_reg == B_LINK)
            next_mem[prev_reg] <= {1'b1, IW'(used_reg - 1'b1)};
        next_rd <= next_mem[cur_reg];
    end

    // Checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(ENTRIES))
        else $error("pool count beyond pool size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        ins_fire |=> used_reg == $past(used_reg) + 1'b1)
        else $error("pool count did not advance on insert");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= ST_FULL)
        else $error("bad result code");

    a_link_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LINK) |-> $past(ins_fire) && $past(pvld_reg))
        else $error("link write without insert");

endmodule

### src/chained_hash_key_value_store_unit.sv
// Channel     Dir  Handshake          Payload
// s_axis      in   tvalid/tready      tuser: mode; tdata: key, value_in
// m_axis      out  tvalid/tready      tdata: status, value_out
// config      in   bucket_count_we    bucket_count
//
// After acceptance the front works out the key remainder, 4 bits a cycle, then
// holds the request until the queue takes it; only then does it accept the next.
// The back reads and checks the bucket head, then reads and compares each chain
// entry visited (pool memory port). An insert behind a chain adds a link write.
// Reset clears bucket head valid bits and the pool count at once; no sweep.
// The queue lets the front work on the next request while the back walks.
module chained_hash_key_value_store_unit
    import chkv_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bucket_count_we,
    input  logic [BCNT_W-1:0] bucket_count,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [127:0]      s_axis_tdata,   // [63:0] key, [127:64] value_in
    input  logic              s_axis_tuser,   // [0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [71:0]       m_axis_tdata    // [2:0] status, [66:3] value_out
);

    logic [BCNT_W-1:0] bcnt_reg;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    req_t              fq_data, qb_data;
    logic [STAT_W-1:0] st;
    logic [VAL_W-1:0]  vo;

    // Bucket count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bcnt_reg <= BCNT_W'(256);
        else if (bucket_count_we)
            bcnt_reg <= bucket_count;
    end

    chkv_front #(.BUCKETS(BUCKETS)) u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .bucket_count (bcnt_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_mode      (s_axis_tuser),
        .in_key       (s_axis_tdata[63:0]),
        .in_value     (s_axis_tdata[127:64]),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    chkv_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    chkv_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_data     (qb_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (st),
        .out_value  (vo)
    );

    assign m_axis_tdata = {5'b0, vo, st};

endmodule
